>>> sv/matrix3_inverse_macros.svh
// Assertion macros used by the matrix inverse top level.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define MI3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix3_inverse assertion failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix3_inverse assertion failed");
`else
`define MI3_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/mi3_pkg.sv
// Shared widths, the adjugate index table and queue types for the matrix inverse.
`default_nettype none
package mi3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int N_ENT      = 9;

    // Exact intermediate widths.
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ADJ_W  = 2 * DATA_WIDTH + 1;
    localparam int HI_W   = ADJ_W - DATA_WIDTH;
    localparam int PP_W   = DATA_WIDTH + HI_W;
    localparam int DET_W  = 3 * DATA_WIDTH + 3;

    // Divider widths: one extra quotient bit flags any quotient of 2^DATA_WIDTH or more.
    localparam int Q_W     = DATA_WIDTH + 1;
    localparam int REM_W   = DET_W + DATA_WIDTH;
    localparam int SHIFT_N = 2 * FRAC_BITS;
    localparam int STAGES  = Q_W + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Adjugate entry k is m[i]*m[j] - m[p]*m[q], with the indices {i, j, p, q} below.
    localparam int ADJ_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // One classified word passed from the front end to the divider.
    typedef struct packed {
        logic [N_ENT-1:0][ADJ_W-1:0] adj;
        logic [DET_W-1:0]            det;
        logic                        singular;
    } work_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage
`default_nettype wire

>>> sv/mi3_front.sv
// Front end: accepts matrices, forms the adjugate and determinant, flags singular ones.
`default_nettype none
module mi3_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m [mi3_pkg::N_ENT],
    input  mi3_pkg::fifo_stat_t                q_stat,
    output logic                               q_push,
    output mi3_pkg::work_t                     q_word
);
    localparam int DW     = mi3_pkg::DATA_WIDTH;
    localparam int N      = mi3_pkg::N_ENT;
    localparam int PROD_W = mi3_pkg::PROD_W;
    localparam int ADJ_W  = mi3_pkg::ADJ_W;
    localparam int PP_W   = mi3_pkg::PP_W;
    localparam int DET_W  = mi3_pkg::DET_W;

    logic [5:0]                vld_reg;
    logic                      f_adv;
    logic signed [DW-1:0]      a_reg    [N];
    logic signed [PROD_W-1:0]  p_reg    [N][2];
    logic signed [DW-1:0]      row1_reg [3];
    logic signed [DW-1:0]      row2_reg [3];
    logic signed [ADJ_W-1:0]   adj2_reg [N];
    logic signed [ADJ_W-1:0]   adj3_reg [N];
    logic signed [ADJ_W-1:0]   adj4_reg [N];
    logic signed [ADJ_W-1:0]   adj5_reg [N];
    logic signed [PP_W-1:0]    ph_reg   [3];
    logic signed [PP_W-1:0]    pl_reg   [3];
    logic signed [DET_W-1:0]   t_reg    [3];
    logic signed [DET_W-1:0]   det5_reg;

    // The whole front pipeline moves unless its last word cannot enter the queue.
    assign f_adv    = !vld_reg[5] || !q_stat.full;
    assign in_stall = !f_adv;
    assign q_push   = vld_reg[5] && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (f_adv)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // Input capture, cofactor products, adjugate, split determinant products, sums.
    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                a_reg[k]    <= m[k];
                p_reg[k][0] <= PROD_W'(a_reg[mi3_pkg::ADJ_IDX[k][0]])
                             * PROD_W'(a_reg[mi3_pkg::ADJ_IDX[k][1]]);
                p_reg[k][1] <= PROD_W'(a_reg[mi3_pkg::ADJ_IDX[k][2]])
                             * PROD_W'(a_reg[mi3_pkg::ADJ_IDX[k][3]]);
                adj2_reg[k] <= ADJ_W'(p_reg[k][0]) - ADJ_W'(p_reg[k][1]);
            end
            for (int j = 0; j < 3; j++)
            begin
                row1_reg[j] <= a_reg[j];
                row2_reg[j] <= row1_reg[j];
                // Row 0 entry times the upper (signed) and lower (unsigned) adjugate halves.
                ph_reg[j] <= PP_W'(row2_reg[j])
                           * PP_W'($signed(adj2_reg[3*j][ADJ_W-1:DW]));
                pl_reg[j] <= PP_W'(row2_reg[j])
                           * PP_W'($signed({1'b0, adj2_reg[3*j][DW-1:0]}));
                t_reg[j]  <= (DET_W'(ph_reg[j]) <<< DW) + DET_W'(pl_reg[j]);
            end
            adj3_reg <= adj2_reg;
            adj4_reg <= adj3_reg;
            adj5_reg <= adj4_reg;
            det5_reg <= t_reg[0] + t_reg[1] + t_reg[2];
        end
    end

    // Queue word, with the singular class decided here.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            q_word.adj[k] = adj5_reg[k];
        end
        q_word.det      = det5_reg;
        q_word.singular = (det5_reg == '0);
    end

endmodule
`default_nettype wire

>>> sv/mi3_fifo.sv
// Short queue between the front end and the divider.
`default_nettype none
module mi3_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mi3_pkg::work_t      wdata,
    input  logic                pop,
    output mi3_pkg::work_t      rdata,
    output mi3_pkg::fifo_stat_t stat
);
    localparam int AW    = mi3_pkg::FIFO_AW;
    localparam int DEPTH = mi3_pkg::FIFO_DEPTH;

    mi3_pkg::work_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

>>> sv/mi3_back.sv
// Back end: nine pipelined restoring dividers, saturation and the output register.
`default_nettype none
module mi3_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mi3_pkg::fifo_stat_t          q_stat,
    input  mi3_pkg::work_t               q_word,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mi3_pkg::DATA_WIDTH-1:0] r [mi3_pkg::N_ENT],
    output logic                         singular,
    output logic                         saturated
);
    localparam int DW     = mi3_pkg::DATA_WIDTH;
    localparam int N      = mi3_pkg::N_ENT;
    localparam int ADJ_W  = mi3_pkg::ADJ_W;
    localparam int DET_W  = mi3_pkg::DET_W;
    localparam int Q_W    = mi3_pkg::Q_W;
    localparam int REM_W  = mi3_pkg::REM_W;
    localparam int STAGES = mi3_pkg::STAGES;
    localparam int LAST   = STAGES - 1;

    logic                 b_adv;
    logic [STAGES-1:0]    vld_reg;
    logic [STAGES-1:0]    sng_reg;
    logic [REM_W-1:0]     rem_reg [STAGES][N];
    logic [Q_W-1:0]       q_reg   [STAGES][N];
    logic [N-1:0]         neg_reg [STAGES];
    logic [DET_W-1:0]     den_reg [STAGES];
    logic [ADJ_W-1:0]     adj_mag [N];
    logic [DET_W-1:0]     det_mag;
    logic [Q_W-1:0]       lim_w   [N];
    logic [Q_W-1:0]       mag_w   [N];
    logic [DW-1:0]        val_w   [N];
    logic [N-1:0]         sat_w;
    logic [DW-1:0]        r_reg   [N];
    logic                 out_valid_reg;
    logic                 sing_out_reg;
    logic                 sat_out_reg;

    // The divider pipeline moves whenever the output register is free or being taken.
    assign b_adv     = !out_valid_reg || !out_stall;
    assign q_pop     = b_adv && !q_stat.empty;
    assign out_valid = out_valid_reg;
    assign singular  = sing_out_reg;
    assign saturated = sat_out_reg;
    assign r         = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            vld_reg       <= {vld_reg[STAGES-2:0], !q_stat.empty};
            out_valid_reg <= vld_reg[LAST];
        end
    end

    // Magnitudes of the adjugate entries and of the determinant.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            adj_mag[k] = q_word.adj[k][ADJ_W-1] ? -q_word.adj[k] : q_word.adj[k];
        end
        det_mag = q_word.det[DET_W-1] ? -q_word.det : q_word.det;
    end

    // Preparation stage: signs, scaled numerators, divisor.
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                neg_reg[0][k] <= q_word.adj[k][ADJ_W-1] ^ q_word.det[DET_W-1];
                rem_reg[0][k] <= REM_W'(adj_mag[k]) << mi3_pkg::SHIFT_N;
                q_reg[0][k]   <= '0;
            end
            den_reg[0] <= det_mag;
            sng_reg[0] <= q_word.singular;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s < STAGES; s++)
    begin : g_step
        localparam int B = Q_W - s;
        logic [REM_W-1:0] dsh;
        logic [REM_W:0]   diff [N];

        assign dsh = REM_W'(den_reg[s-1]) << B;

        always_comb
        begin
            for (int k = 0; k < N; k++)
            begin
                diff[k] = {1'b0, rem_reg[s-1][k]} - {1'b0, dsh};
            end
        end

        always_ff @(posedge clk)
        begin
            if (b_adv)
            begin
                for (int k = 0; k < N; k++)
                begin
                    if (!diff[k][REM_W])
                    begin
                        rem_reg[s][k] <= diff[k][REM_W-1:0];
                        q_reg[s][k]   <= q_reg[s-1][k] | (Q_W'(1) << B);
                    end
                    else
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k];
                        q_reg[s][k]   <= q_reg[s-1][k];
                    end
                end
                neg_reg[s] <= neg_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                sng_reg[s] <= sng_reg[s-1];
            end
        end
    end

    // Clip to the signed range, apply the sign, zero everything for a singular matrix.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            lim_w[k] = (Q_W'(1) << (DW - 1)) - (neg_reg[LAST][k] ? Q_W'(0) : Q_W'(1));
            sat_w[k] = (q_reg[LAST][k] > lim_w[k]) && !sng_reg[LAST];
            mag_w[k] = sat_w[k] ? lim_w[k] : q_reg[LAST][k];
            val_w[k] = neg_reg[LAST][k] ? -mag_w[k][DW-1:0] : mag_w[k][DW-1:0];
            if (sng_reg[LAST])
            begin
                val_w[k] = '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            r_reg        <= val_w;
            sing_out_reg <= sng_reg[LAST];
            sat_out_reg  <= |sat_w;
        end
    end

endmodule
`default_nettype wire

>>> sv/matrix3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
//   channel   valid      stall      word
//   input     in_valid   in_stall   m00 .. m22 (signed Q16.16)
//   output    out_valid  out_stall  r00 .. r22, singular, saturated
//
// One matrix is accepted per cycle while in_stall is low; the divider has nine lanes of 33 quotient stages.
// Reset clears only control state; there is no clearing pass.
// A stalled output holds the divider; the front end keeps accepting until its
// four-word queue is full and its last stage holds a word, and only then raises in_stall.
`default_nettype none
`include "matrix3_inverse_macros.svh"
module matrix3_inverse (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m00,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m01,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m02,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m10,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m11,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m12,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m20,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m21,
    input  logic signed [mi3_pkg::DATA_WIDTH-1:0] m22,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r00,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r01,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r02,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r10,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r11,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r12,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r20,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r21,
    output logic signed [mi3_pkg::DATA_WIDTH-1:0] r22,
    output logic                                 singular,
    output logic                                 saturated
);
    localparam int DW = mi3_pkg::DATA_WIDTH;
    localparam int N  = mi3_pkg::N_ENT;

    logic signed [DW-1:0] m_arr [N];
    logic [DW-1:0]        r_arr [N];
    mi3_pkg::work_t       push_word;
    mi3_pkg::work_t       pop_word;
    mi3_pkg::fifo_stat_t  q_stat;
    logic                 q_push;
    logic                 q_pop;

    // Gather the input word and spread the result word.
    assign m_arr[0] = m00;
    assign m_arr[1] = m01;
    assign m_arr[2] = m02;
    assign m_arr[3] = m10;
    assign m_arr[4] = m11;
    assign m_arr[5] = m12;
    assign m_arr[6] = m20;
    assign m_arr[7] = m21;
    assign m_arr[8] = m22;

    assign r00 = $signed(r_arr[0]);
    assign r01 = $signed(r_arr[1]);
    assign r02 = $signed(r_arr[2]);
    assign r10 = $signed(r_arr[3]);
    assign r11 = $signed(r_arr[4]);
    assign r12 = $signed(r_arr[5]);
    assign r20 = $signed(r_arr[6]);
    assign r21 = $signed(r_arr[7]);
    assign r22 = $signed(r_arr[8]);

    mi3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .m        (m_arr),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    mi3_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (push_word),
        .pop   (q_pop),
        .rdata (pop_word),
        .stat  (q_stat)
    );

    mi3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_word    (pop_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .r         (r_arr),
        .singular  (singular),
        .saturated (saturated)
    );

    // A singular result carries all-zero entries and no saturation.
    `MI3_ASSERT_IMPL(a_singular_zero, clk, rst_n, out_valid && singular, !saturated && r00 == '0 && r01 == '0 && r02 == '0 && r10 == '0 && r11 == '0 && r12 == '0 && r20 == '0 && r21 == '0 && r22 == '0)
    // The input side only stalls when the queue is full.
    `MI3_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, q_stat.full)
    // The divider never takes a word from an empty queue.
    `MI3_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty)
    // A word pushed into an empty queue without a pop is visible next cycle.
    `MI3_ASSERT_NEXT(a_push_visible, clk, rst_n, q_push && !q_pop, !q_stat.empty)

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 100ps
`default_nettype none

// Holds the predicted inverses in arrival order and compares each result word.
class inverse_scoreboard;
    typedef struct {
        logic signed [31:0] ent [9];
        logic               singular;
        logic               saturated;
    } inverse_t;

    inverse_t pending [$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    // Exact adjugate, determinant and truncated, saturated quotient per entry.
    function void note_matrix(logic signed [31:0] m [9]);
        logic signed [64:0]  adj [9];
        logic signed [99:0]  det;
        logic signed [99:0]  num;
        logic signed [99:0]  den;
        logic signed [99:0]  quo;
        logic signed [99:0]  hi_lim;
        logic signed [99:0]  lo_lim;
        inverse_t            res;
        int                  k;
        adj[0] = 65'(m[4]) * m[8] - 65'(m[5]) * m[7];
        adj[1] = 65'(m[2]) * m[7] - 65'(m[1]) * m[8];
        adj[2] = 65'(m[1]) * m[5] - 65'(m[2]) * m[4];
        adj[3] = 65'(m[5]) * m[6] - 65'(m[3]) * m[8];
        adj[4] = 65'(m[0]) * m[8] - 65'(m[2]) * m[6];
        adj[5] = 65'(m[2]) * m[3] - 65'(m[0]) * m[5];
        adj[6] = 65'(m[3]) * m[7] - 65'(m[4]) * m[6];
        adj[7] = 65'(m[1]) * m[6] - 65'(m[0]) * m[7];
        adj[8] = 65'(m[0]) * m[4] - 65'(m[1]) * m[3];
        det = 100'(m[0]) * adj[0] + 100'(m[1]) * adj[3] + 100'(m[2]) * adj[6];
        hi_lim = 100'sd2147483647;
        lo_lim = -100'sd2147483648;
        res.singular = (det == 0);
        res.saturated = 1'b0;
        for (k = 0; k < 9; k++)
        begin
            if (res.singular)
            begin
                res.ent[k] = '0;
            end
            else
            begin
                // Signed division truncates toward zero, as required.
                num = 100'(adj[k]) <<< 32;
                den = det;
                quo = num / den;
                if (quo > hi_lim)
                begin
                    quo = hi_lim;
                    res.saturated = 1'b1;
                end
                else if (quo < lo_lim)
                begin
                    quo = lo_lim;
                    res.saturated = 1'b1;
                end
                res.ent[k] = quo[31:0];
            end
        end
        pending.push_back(res);
    endfunction

    task check_result(logic signed [31:0] r [9], logic sing, logic sat);
        inverse_t exp_res;
        int       k;
        if (pending.size() == 0)
        begin
            report("result word with nothing expected");
            return;
        end
        exp_res = pending.pop_front();
        for (k = 0; k < 9; k++)
            if (r[k] !== exp_res.ent[k])
                report($sformatf("entry %0d got %0d expected %0d", k, r[k], exp_res.ent[k]));
        if (sing !== exp_res.singular)
            report($sformatf("singular got %b expected %b", sing, exp_res.singular));
        if (sat !== exp_res.saturated)
            report($sformatf("saturated got %b expected %b", sat, exp_res.saturated));
    endtask

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH: %s", msg);
    endtask
endclass

module tb_top;
    localparam int LATENCY = 42;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] m [9];
    logic signed [31:0] r [9];
    logic singular;
    logic saturated;

    // Idling profile: 0 receiver-heavy, 1 sender-heavy, 2 none.
    int  idle_phase = 0;
    bit  hold_off = 1'b0;
    bit  hold_done = 1'b0;
    inverse_scoreboard board = new();

    always #1 clk = ~clk;

    initial
    begin
        for (int k = 0; k < 9; k++)
            m[k] = '0;
    end

    matrix3_inverse DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(m[0]), .m01(m[1]), .m02(m[2]),
        .m10(m[3]), .m11(m[4]), .m12(m[5]),
        .m20(m[6]), .m21(m[7]), .m22(m[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .r00(r[0]), .r01(r[1]), .r02(r[2]),
        .r10(r[3]), .r11(r[4]), .r12(r[5]),
        .r20(r[6]), .r21(r[7]), .r22(r[8]),
        .singular(singular), .saturated(saturated)
    );

    // Receiver stall: random per profile, or held high during a long hold-off.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (idle_phase == 0)
            out_stall <= ($urandom_range(99) < 46);
        else if (idle_phase == 1)
            out_stall <= ($urandom_range(99) < 28);
        else
            out_stall <= 1'b0;
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(r, singular, saturated);
    end

    // Long receiver hold-off counted in its own process.
    initial
    begin
        wait (idle_phase == 2);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
        hold_done = 1'b1;
    end

    // Offer one word and hold it until accepted, with random gaps before it.
    task automatic send_matrix(logic signed [31:0] v [9]);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 28 : (idle_phase == 1) ? 46 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++)
            m[k] <= v[k];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_matrix(v);
    endtask

    function automatic logic signed [31:0] rand_entry(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(262143)) - 131072;
            2: return $signed($urandom_range(8191)) - 4096;
            default: return '0;
        endcase
    endfunction

    task automatic random_matrix();
        logic signed [31:0] v [9];
        int kind;
        int shape;
        kind = $urandom_range(2);
        shape = $urandom_range(9);
        for (int k = 0; k < 9; k++)
            v[k] = rand_entry(kind);
        if (shape == 0)
        begin
            // Repeat a row so the matrix is singular.
            for (int k = 0; k < 3; k++)
                v[6 + k] = v[k];
        end
        else if (shape == 1)
        begin
            // Near-identity scaled down so the inverse clips.
            for (int k = 0; k < 9; k++)
                v[k] = (k % 4 == 0) ? $signed($urandom_range(3)) - 1 : '0;
            v[0] = $urandom_range(1, 2);
        end
        else if (shape == 2)
        begin
            // Large positive diagonal: diagonal-dominant unless the entries are full-range.
            for (int k = 0; k < 9; k++)
                if (k % 4 == 0)
                    v[k] = $signed($urandom_range(32'h40000, 32'h80000));
        end
        send_matrix(v);
    endtask

    task automatic directed_set();
        logic signed [31:0] v [9];
        logic signed [31:0] one;
        one = 32'sh10000;
        // All zero: singular.
        for (int k = 0; k < 9; k++) v[k] = '0;
        send_matrix(v);
        // Identity.
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? one : '0;
        send_matrix(v);
        // Negative identity.
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? -one : '0;
        send_matrix(v);
        // Tiny diagonal: positive and negative saturation.
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? 32'sd1 : '0;
        send_matrix(v);
        v[0] = -32'sd1;
        send_matrix(v);
        // Extremes on the diagonal.
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? 32'sh7fffffff : '0;
        send_matrix(v);
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? 32'sh80000000 : '0;
        send_matrix(v);
        // All entries at an extreme: singular.
        for (int k = 0; k < 9; k++) v[k] = 32'sh80000000;
        send_matrix(v);
        for (int k = 0; k < 9; k++) v[k] = 32'sh7fffffff;
        send_matrix(v);
        // Mixed extremes, full permutation pattern.
        for (int k = 0; k < 9; k++) v[k] = '0;
        v[1] = 32'sh80000000; v[5] = 32'sh7fffffff; v[6] = 32'sh80000000;
        send_matrix(v);
        v[1] = -1; v[5] = 32'sh80000000; v[6] = 32'sh7fffffff;
        send_matrix(v);
        // Alternating bit patterns.
        for (int k = 0; k < 9; k++) v[k] = (k % 2) ? 32'sh55555555 : 32'shaaaaaaaa;
        send_matrix(v);
        for (int k = 0; k < 9; k++) v[k] = 32'(k * k + 1) * one + 32'(k);
        send_matrix(v);
        // Exact division case: 2x identity.
        for (int k = 0; k < 9; k++) v[k] = (k % 4 == 0) ? 2 * one : '0;
        send_matrix(v);
    endtask

    // Main sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_set();
        for (int n = 0; n < 170; n++)
            random_matrix();
        // Pause the sender until all results are back.
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        idle_phase = 1;
        for (int n = 0; n < 170; n++)
            random_matrix();
        idle_phase = 2;
        while (!hold_done || board.pending.size() < 200)
        begin
            if (hold_done && board.pending.size() == 0 && $urandom_range(1))
                break;
            random_matrix();
            if (hold_done)
                break;
        end
        for (int n = 0; n < 150; n++)
            random_matrix();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
